// ----- hdl/cffa_pkg.sv -----
// Shared types, constants and helpers for the coalescing first-fit allocator.
// No dependencies; used by the top level, the node RAM user and the checker.
package cffa_pkg;

  localparam int unsigned NODE_COUNT = 256;
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned IDX_BITS   = $clog2(NODE_COUNT);
  // link values run 0..NODE_COUNT, the top value meaning "no node"
  localparam int unsigned LINK_BITS  = $clog2(NODE_COUNT + 1);

  localparam logic [LINK_BITS-1:0] NODE_NONE  = LINK_BITS'(NODE_COUNT);
  localparam logic [LINK_BITS-1:0] STEP_LIMIT = LINK_BITS'(NODE_COUNT);
  localparam logic [ADDR_BITS-1:0] ADDR_MASK  = '1;
  localparam logic [ADDR_BITS:0]   ADDR_SPAN  = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [ADDR_BITS:0]   GRAIN_MASK = (ADDR_BITS + 1)'(15);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NO_NODE = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [ADDR_BITS-1:0] block_addr;
    logic [ADDR_BITS-1:0] block_size;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_BITS-1:0] grant_addr;
    logic [ADDR_BITS-1:0] free_total;
  } rsp_t;

  // one list node as stored in the node RAM
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] length;
    logic [LINK_BITS-1:0] link;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

  function automatic logic node_ok(input logic [LINK_BITS-1:0] n);
    return n < NODE_NONE;
  endfunction

  // saturating add at the top of the address space
  function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] x,
                                                   input logic [ADDR_BITS-1:0] y);
    logic [ADDR_BITS:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[ADDR_BITS] ? ADDR_MASK : sum[ADDR_BITS-1:0];
  endfunction

endpackage

// ----- hdl/cffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/coalescing_first_fit_allocator.sv -----
// Address-ordered first-fit free-list allocator with coalescing on free.
// Depends on cffa_pkg and cffa_ram (node pool storage).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------
//   request | in        | in_valid_i / in_ready_o   | in_req_i  (req_t)
//   result  | out       | out_valid_o / out_ready_i | out_rsp_o (rsp_t)
//
// One request at a time. A request walks k list nodes, k up to NODE_COUNT,
// then decides; an allocate may return a node to the pool on an exact fit,
// and a free may merge or write a new node, before the response. The walk
// reads one node per cycle through the single read port of the node RAM.
// Reset is immediate: per-node valid flops give unwritten nodes their
// default pool link, so there is no clearing pass.
// A result waiting on out_ready_i holds the next result back in the response state.
module coalescing_first_fit_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cffa_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cffa_pkg::rsp_t out_rsp_o
);
  import cffa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_MERGE = 8'b0000_1000,
    S_SPARE = 8'b0001_0000,
    S_LINK  = 8'b0010_0000,
    S_RET   = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  // control state
  state_e                state_q, state_d;
  logic [LINK_BITS-1:0]  head_q, head_d;
  logic [LINK_BITS-1:0]  spare_q, spare_d;
  logic [ADDR_BITS-1:0]  fb_q, fb_d;
  logic [NODE_COUNT-1:0] valid_q, valid_d;
  logic                  out_valid_q, out_valid_d;

  // per-request working registers
  req_type_e             kind_q, kind_d;
  logic [ADDR_BITS-1:0]  a_q, a_d;
  logic [ADDR_BITS-1:0]  s_q, s_d;
  logic [ADDR_BITS:0]    a_end_q, a_end_d;
  logic [ADDR_BITS:0]    r_q, r_d;
  logic [LINK_BITS-1:0]  prev_idx_q, prev_idx_d;
  logic                  prev_ok_q, prev_ok_d;
  entry_t                prev_ent_q, prev_ent_d;
  logic [ADDR_BITS:0]    prev_end_q, prev_end_d;
  logic [LINK_BITS-1:0]  cur_idx_q, cur_idx_d;
  logic                  cur_ok_q, cur_ok_d;
  entry_t                cur_ent_q, cur_ent_d;
  logic [LINK_BITS-1:0]  steps_q, steps_d;
  logic [IDX_BITS-1:0]   rd_idx_q, rd_idx_d;
  status_e               status_q, status_d;
  logic [ADDR_BITS-1:0]  grant_q, grant_d;
  rsp_t                  out_rsp_q, out_rsp_d;

  // node RAM port signals
  logic                  ram_we, ram_re;
  logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
  entry_t                wr_ent;
  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t                rd_ent;

  // request decode helpers
  logic [ADDR_BITS:0]    req_end, span_rem, merged_end;
  logic [ADDR_BITS-1:0]  s_clip;
  logic                  walk_limit, walk_fit, walk_below, walk_stop;

  cffa_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // never-written nodes read as their reset pool link
  always_comb begin
    if (valid_q[rd_idx_q]) begin
      rd_ent = entry_t'(ram_rdata);
    end else begin
      rd_ent.base   = '0;
      rd_ent.length = '0;
      rd_ent.link   = LINK_BITS'(rd_idx_q) + LINK_BITS'(1);
    end
  end

  // clip a freed extent so it does not run past the top of the space
  assign req_end  = {1'b0, in_req_i.block_addr} + {1'b0, in_req_i.block_size};
  assign span_rem = ADDR_SPAN - {1'b0, in_req_i.block_addr};
  assign s_clip   = (req_end > ADDR_SPAN) ? span_rem[ADDR_BITS-1:0] : in_req_i.block_size;

  // walk stop conditions on the node just read
  assign walk_limit = (steps_q == STEP_LIMIT);
  assign walk_fit   = ({1'b0, rd_ent.length} >= r_q);
  assign walk_below = (rd_ent.base < a_q);
  assign walk_stop  = walk_limit || ((kind_q == REQ_ALLOC) ? walk_fit : !walk_below);

  assign merged_end = {1'b0, prev_ent_q.base} + {1'b0, prev_ent_q.length};

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    spare_d     = spare_q;
    fb_d        = fb_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    a_d         = a_q;
    s_d         = s_q;
    a_end_d     = a_end_q;
    r_d         = r_q;
    prev_idx_d  = prev_idx_q;
    prev_ok_d   = prev_ok_q;
    prev_ent_d  = prev_ent_q;
    prev_end_d  = prev_end_q;
    cur_idx_d   = cur_idx_q;
    cur_ok_d    = cur_ok_q;
    cur_ent_d   = cur_ent_q;
    steps_d     = steps_q;
    rd_idx_d    = rd_idx_q;
    status_d    = status_q;
    grant_d     = grant_q;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    wr_ent      = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d     = in_req_i.req_type;
          a_d        = in_req_i.block_addr;
          s_d        = s_clip;
          a_end_d    = {1'b0, in_req_i.block_addr} + {1'b0, s_clip};
          r_d        = ({1'b0, in_req_i.block_size} + GRAIN_MASK) & ~GRAIN_MASK;
          prev_ok_d  = 1'b0;
          prev_idx_d = NODE_NONE;
          steps_d    = '0;
          cur_idx_d  = head_q;
          grant_d    = '0;
          status_d   = ST_DONE;
          if (node_ok(head_q)) begin
            ram_re    = 1'b1;
            ram_raddr = head_q[IDX_BITS-1:0];
            rd_idx_d  = head_q[IDX_BITS-1:0];
            state_d   = S_WALK;
          end else begin
            cur_ok_d = 1'b0;
            state_d  = S_DEC;
          end
        end
      end

      // one node per cycle; read of the next node issued here
      S_WALK: begin
        if (walk_stop) begin
          cur_ent_d = rd_ent;
          cur_ok_d  = !(walk_limit && (kind_q == REQ_ALLOC));
          state_d   = S_DEC;
        end else begin
          prev_idx_d = cur_idx_q;
          prev_ok_d  = 1'b1;
          prev_ent_d = rd_ent;
          prev_end_d = {1'b0, rd_ent.base} + {1'b0, rd_ent.length};
          cur_idx_d  = rd_ent.link;
          steps_d    = steps_q + LINK_BITS'(1);
          if (node_ok(rd_ent.link)) begin
            ram_re    = 1'b1;
            ram_raddr = rd_ent.link[IDX_BITS-1:0];
            rd_idx_d  = rd_ent.link[IDX_BITS-1:0];
          end else begin
            cur_ok_d = 1'b0;
            state_d  = S_DEC;
          end
        end
      end

      S_DEC: begin
        if (kind_q == REQ_ALLOC) begin
          if (!cur_ok_q) begin
            status_d = ST_NO_FIT;
            state_d  = S_RESP;
          end else begin
            grant_d = cur_ent_q.base;
            fb_d    = ({1'b0, fb_q} >= r_q) ? fb_q - r_q[ADDR_BITS-1:0] : '0;
            if ({1'b0, cur_ent_q.length} == r_q) begin
              // exact fit: unlink, then return the node to the pool
              if (prev_ok_q) begin
                ram_we         = 1'b1;
                ram_waddr      = prev_idx_q[IDX_BITS-1:0];
                wr_ent         = prev_ent_q;
                wr_ent.link    = cur_ent_q.link;
              end else begin
                head_d = cur_ent_q.link;
              end
              state_d = S_RET;
            end else begin
              // split off the front of the extent
              ram_we        = 1'b1;
              ram_waddr     = cur_idx_q[IDX_BITS-1:0];
              wr_ent        = cur_ent_q;
              wr_ent.base   = cur_ent_q.base + r_q[ADDR_BITS-1:0];
              wr_ent.length = cur_ent_q.length - r_q[ADDR_BITS-1:0];
              state_d       = S_RESP;
            end
          end
        end else begin
          if (prev_ok_q && (prev_end_q == {1'b0, a_q})) begin
            // grows the predecessor; successor merge checked next
            prev_ent_d.length = sat_add(prev_ent_q.length, s_q);
            fb_d              = sat_add(fb_q, s_q);
            state_d           = S_MERGE;
          end else if (cur_ok_q && (a_end_q == {1'b0, cur_ent_q.base})) begin
            // grows the successor downward
            ram_we        = 1'b1;
            ram_waddr     = cur_idx_q[IDX_BITS-1:0];
            wr_ent        = cur_ent_q;
            wr_ent.base   = a_q;
            wr_ent.length = sat_add(cur_ent_q.length, s_q);
            fb_d          = sat_add(fb_q, s_q);
            state_d       = S_RESP;
          end else if (!node_ok(spare_q)) begin
            status_d = ST_NO_NODE;
            state_d  = S_RESP;
          end else begin
            // fetch the spare node to learn the next spare
            ram_re    = 1'b1;
            ram_raddr = spare_q[IDX_BITS-1:0];
            rd_idx_d  = spare_q[IDX_BITS-1:0];
            state_d   = S_SPARE;
          end
        end
      end

      S_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = prev_idx_q[IDX_BITS-1:0];
        wr_ent    = prev_ent_q;
        if (cur_ok_q && (merged_end == {1'b0, cur_ent_q.base})) begin
          wr_ent.length = sat_add(prev_ent_q.length, cur_ent_q.length);
          wr_ent.link   = cur_ent_q.link;
          state_d       = S_RET;
        end else begin
          state_d = S_RESP;
        end
      end

      // new node gets the extent and links to the walk's stop node
      S_SPARE: begin
        spare_d       = rd_ent.link;
        ram_we        = 1'b1;
        ram_waddr     = rd_idx_q;
        wr_ent.base   = a_q;
        wr_ent.length = s_q;
        wr_ent.link   = cur_idx_q;
        fb_d          = sat_add(fb_q, s_q);
        if (prev_ok_q) begin
          state_d = S_LINK;
        end else begin
          head_d  = LINK_BITS'(rd_idx_q);
          state_d = S_RESP;
        end
      end

      S_LINK: begin
        ram_we      = 1'b1;
        ram_waddr   = prev_idx_q[IDX_BITS-1:0];
        wr_ent      = prev_ent_q;
        wr_ent.link = LINK_BITS'(rd_idx_q);
        state_d     = S_RESP;
      end

      // push the removed node onto the spare pool
      S_RET: begin
        ram_we      = 1'b1;
        ram_waddr   = cur_idx_q[IDX_BITS-1:0];
        wr_ent      = cur_ent_q;
        wr_ent.link = spare_q;
        spare_d     = cur_idx_q;
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_rsp_d.status     = status_q;
          out_rsp_d.grant_addr = (status_q == ST_DONE) ? grant_q : '0;
          out_rsp_d.free_total = fb_q;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NODE_NONE;
      spare_q     <= '0;
      fb_q        <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      spare_q     <= spare_d;
      fb_q        <= fb_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    a_q        <= a_d;
    s_q        <= s_d;
    a_end_q    <= a_end_d;
    r_q        <= r_d;
    prev_idx_q <= prev_idx_d;
    prev_ok_q  <= prev_ok_d;
    prev_ent_q <= prev_ent_d;
    prev_end_q <= prev_end_d;
    cur_idx_q  <= cur_idx_d;
    cur_ok_q   <= cur_ok_d;
    cur_ent_q  <= cur_ent_d;
    steps_q    <= steps_d;
    rd_idx_q   <= rd_idx_d;
    status_q   <= status_d;
    grant_q    <= grant_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hdl/cffa_checker.sv -----
// Port-level checks for the coalescing first-fit allocator, bound to the top.
// Depends on cffa_pkg and coalescing_first_fit_allocator.
module cffa_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cffa_pkg::rsp_t out_rsp_o
);
  import cffa_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request in flight: a transfer closes the request port
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request port open right after a transfer");

  // failed requests grant nothing
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_DONE) |-> (out_rsp_o.grant_addr == '0))
    else $error("grant address on a failed request");

endmodule

bind coalescing_first_fit_allocator cffa_port_checks u_cffa_checker (.*);
